@@ rtl/cma_pkg.sv @@
// Shared types and codes for the congruence merge accumulator.
// Holds the sequencer step codes, status codes and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cma_pkg;

  localparam int unsigned DW = 64;
  localparam int unsigned IW = 32;

  // Result status codes.
  localparam logic [1:0] ST_VALID = 2'd0;
  localparam logic [1:0] ST_NOSOL = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Sequencer steps. A step ending in L launches a unit, one ending in W waits for it.
  localparam logic [5:0] STP_IDLE = 6'd0;
  localparam logic [5:0] STP_LOAD = 6'd1;
  localparam logic [5:0] STP_G0L  = 6'd2;
  localparam logic [5:0] STP_G0W  = 6'd3;
  localparam logic [5:0] STP_GCHK = 6'd4;
  localparam logic [5:0] STP_GL   = 6'd5;
  localparam logic [5:0] STP_GW   = 6'd6;
  localparam logic [5:0] STP_A2L  = 6'd7;
  localparam logic [5:0] STP_A2W  = 6'd8;
  localparam logic [5:0] STP_A1L  = 6'd9;
  localparam logic [5:0] STP_A1W  = 6'd10;
  localparam logic [5:0] STP_DGL  = 6'd11;
  localparam logic [5:0] STP_DGW  = 6'd12;
  localparam logic [5:0] STP_DGC  = 6'd13;
  localparam logic [5:0] STP_M2L  = 6'd14;
  localparam logic [5:0] STP_M2W  = 6'd15;
  localparam logic [5:0] STP_QL   = 6'd16;
  localparam logic [5:0] STP_QW   = 6'd17;
  localparam logic [5:0] STP_LL   = 6'd18;
  localparam logic [5:0] STP_LW   = 6'd19;
  localparam logic [5:0] STP_LC   = 6'd20;
  localparam logic [5:0] STP_QML  = 6'd21;
  localparam logic [5:0] STP_QMW  = 6'd22;
  localparam logic [5:0] STP_ICHK = 6'd23;
  localparam logic [5:0] STP_IDL  = 6'd24;
  localparam logic [5:0] STP_IDW  = 6'd25;
  localparam logic [5:0] STP_IML  = 6'd26;
  localparam logic [5:0] STP_IMW  = 6'd27;
  localparam logic [5:0] STP_IFIN = 6'd28;
  localparam logic [5:0] STP_KML  = 6'd29;
  localparam logic [5:0] STP_KMW  = 6'd30;
  localparam logic [5:0] STP_KDL  = 6'd31;
  localparam logic [5:0] STP_KDW  = 6'd32;
  localparam logic [5:0] STP_BML  = 6'd33;
  localparam logic [5:0] STP_BMW  = 6'd34;
  localparam logic [5:0] STP_RDL  = 6'd35;
  localparam logic [5:0] STP_RDW  = 6'd36;
  localparam logic [5:0] STP_XDL  = 6'd37;
  localparam logic [5:0] STP_XDW  = 6'd38;
  localparam logic [5:0] STP_FIN1 = 6'd39;
  localparam logic [5:0] STP_FIN2 = 6'd40;
  localparam logic [5:0] STP_FIN3 = 6'd41;
  localparam logic [5:0] STP_FNS  = 6'd42;
  localparam logic [5:0] STP_FOV  = 6'd43;
  localparam logic [5:0] STP_OUT  = 6'd44;

  typedef struct packed {
    logic [5:0] step;
    logic       accept;
    logic       out_load;
  } cma_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic gy_zero;
    logic r1_zero;
    logic nosol;
    logic lcm_ovf;
    logic acc_fail;
  } cma_stat_t;

endpackage

`default_nettype wire

@@ rtl/cma_div.sv @@
// Iterative 64-bit restoring divider, one quotient bit per cycle.
// Uses cma_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module cma_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [cma_pkg::DW-1:0] num,
  input  wire logic [cma_pkg::DW-1:0] den,
  output logic                      done,
  output logic [cma_pkg::DW-1:0]    quo,
  output logic [cma_pkg::DW-1:0]    rem
);
  import cma_pkg::*;

  logic [6:0]    cnt_r;
  logic          done_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] quo_r;
  logic [DW-1:0] den_r;
  logic [DW+1:0] trial;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {1'b0, rem_r, quo_r[DW-1]} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'(DW);
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
      end else if (cnt_r != '0) begin
        if (!trial[DW+1]) begin
          rem_r <= trial[DW-1:0];
          quo_r <= {quo_r[DW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[DW-2:0], quo_r[DW-1]};
          quo_r <= {quo_r[DW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/cma_mul.sv @@
// Iterative 64 x 64 shift-add multiplier with a 128-bit product, one bit per cycle.
// Uses cma_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

module cma_mul (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [cma_pkg::DW-1:0] op_a,
  input  wire logic [cma_pkg::DW-1:0] op_b,
  output logic                        done,
  output logic [cma_pkg::DW-1:0]      prod_hi,
  output logic [cma_pkg::DW-1:0]      prod_lo
);
  import cma_pkg::*;

  logic [6:0]    cnt_r;
  logic          done_r;
  logic [DW-1:0] hi_r;
  logic [DW-1:0] lo_r;
  logic [DW-1:0] a_r;
  logic [DW:0]   sum;

  assign sum = lo_r[0] ? ({1'b0, hi_r} + {1'b0, a_r}) : {1'b0, hi_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 7'(DW);
        hi_r  <= '0;
        lo_r  <= op_b;
        a_r   <= op_a;
      end else if (cnt_r != '0) begin
        hi_r  <= sum[DW:1];
        lo_r  <= {sum[0], lo_r[DW-1:1]};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign prod_hi = hi_r;
  assign prod_lo = lo_r;

endmodule

`default_nettype wire

@@ rtl/cma_datapath.sv @@
// Datapath of the merge: accumulator, working registers, shared divider and multiplier.
// Depends on cma_pkg, cma_div and cma_mul; driven by the step code from cma_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module cma_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cma_pkg::cma_cmd_t      cmd,
  input  wire logic [cma_pkg::IW-1:0] in_residue,
  input  wire logic [cma_pkg::IW-1:0] in_modulus,
  output cma_pkg::cma_stat_t          stat,
  output logic [cma_pkg::DW-1:0]      out_merged_residue,
  output logic [cma_pkg::DW-1:0]      out_merged_modulus,
  output logic [1:0]                  out_status
);
  import cma_pkg::*;

  logic [DW-1:0] acc_res_r, acc_mod_r;
  logic [1:0]    acc_st_r;
  logic [IW-1:0] a2_r, b2_r, am2_r, diff_r;
  logic [DW-1:0] gx_r, gy_r, dg_r, m2_r, q_r, lcm_r;
  logic [DW-1:0] r0_r, r1_r, t0_r, t1_r, qq_r, tr_r;
  logic [DW-1:0] inv_r, kp_r, k_r, bk_r, rr_r, mm_r, rho_r, x1_r;
  logic          nosol_r, lovf_r, c1_r, lt_r;
  logic [DW-1:0] res_o_r, mod_o_r;
  logic [1:0]    st_o_r;

  logic          div_go, mul_go, div_done, mul_done;
  logic [DW-1:0] div_n, div_d, div_q, div_r, mul_a, mul_b, p_hi, p_lo;
  logic [DW-1:0] a2_x, b2_x, mx, t1_abs, tt, t0_fix;
  logic [DW:0]   rho_s, sum1, sum2;
  logic [IW-1:0] am1;

  assign a2_x   = {{(DW-IW){1'b0}}, a2_r};
  assign b2_x   = {{(DW-IW){1'b0}}, b2_r};
  assign mx     = (acc_res_r > a2_x) ? acc_res_r : a2_x;
  assign t1_abs = t1_r[DW-1] ? (~t1_r + 64'd1) : t1_r;
  // Subtracting q * t1 with the sign of t1 folded in.
  assign tt     = t1_r[DW-1] ? (t0_r + p_lo) : (t0_r - p_lo);
  assign t0_fix = t0_r[DW-1] ? (t0_r + m2_r) : t0_r;
  assign am1    = div_r[IW-1:0];
  assign rho_s  = {1'b0, rr_r} + {1'b0, bk_r};
  assign sum1   = {1'b0, mx - mm_r} + {1'b0, rho_r};
  assign sum2   = {1'b0, x1_r} + {1'b0, lcm_r};

  always_comb begin
    div_go = 1'b0;
    div_n  = '0;
    div_d  = '0;
    mul_go = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.step)
      STP_G0L: begin div_go = 1'b1; div_n = acc_mod_r; div_d = b2_x; end
      STP_GL:  begin div_go = 1'b1; div_n = gx_r;      div_d = gy_r; end
      STP_A2L: begin div_go = 1'b1; div_n = a2_x;      div_d = b2_x; end
      STP_A1L: begin div_go = 1'b1; div_n = acc_res_r; div_d = b2_x; end
      STP_DGL: begin div_go = 1'b1; div_n = {{(DW-IW){1'b0}}, diff_r}; div_d = gx_r; end
      STP_M2L: begin div_go = 1'b1; div_n = b2_x;      div_d = gx_r; end
      STP_QL:  begin div_go = 1'b1; div_n = acc_mod_r; div_d = gx_r; end
      STP_LL:  begin mul_go = 1'b1; mul_a = q_r;       mul_b = b2_x; end
      STP_QML: begin div_go = 1'b1; div_n = q_r;       div_d = m2_r; end
      STP_IDL: begin div_go = 1'b1; div_n = r0_r;      div_d = r1_r; end
      STP_IML: begin mul_go = 1'b1; mul_a = qq_r;      mul_b = t1_abs; end
      STP_KML: begin mul_go = 1'b1; mul_a = dg_r;      mul_b = inv_r; end
      STP_KDL: begin div_go = 1'b1; div_n = kp_r;      div_d = m2_r; end
      STP_BML: begin mul_go = 1'b1; mul_a = acc_mod_r; mul_b = k_r; end
      STP_RDL: begin div_go = 1'b1; div_n = acc_res_r; div_d = lcm_r; end
      STP_XDL: begin div_go = 1'b1; div_n = mx;        div_d = lcm_r; end
      default: ;
    endcase
  end

  cma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_go),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  cma_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .done    (mul_done),
    .prod_hi (p_hi),
    .prod_lo (p_lo)
  );

  // Accumulator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_res_r <= '0;
      acc_mod_r <= 64'd1;
      acc_st_r  <= ST_VALID;
    end else begin
      case (cmd.step)
        STP_LOAD: begin
          acc_res_r <= a2_x;
          acc_mod_r <= b2_x;
          acc_st_r  <= ST_VALID;
        end
        STP_FNS: begin
          acc_res_r <= '0;
          acc_mod_r <= '0;
          acc_st_r  <= ST_NOSOL;
        end
        STP_FOV: begin
          acc_res_r <= '0;
          acc_mod_r <= '0;
          acc_st_r  <= ST_OVF;
        end
        STP_FIN3: begin
          if (c1_r || (lt_r && sum2[DW])) begin
            acc_res_r <= '0;
            acc_mod_r <= '0;
            acc_st_r  <= ST_OVF;
          end else begin
            acc_res_r <= lt_r ? sum2[DW-1:0] : x1_r;
            acc_mod_r <= lcm_r;
            acc_st_r  <= ST_VALID;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers of the merge.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      a2_r <= in_residue;
      b2_r <= (in_modulus == '0) ? IW'(1) : in_modulus;
    end
    if (cmd.out_load) begin
      res_o_r <= (acc_st_r == ST_VALID) ? acc_res_r : '0;
      mod_o_r <= (acc_st_r == ST_VALID) ? acc_mod_r : '0;
      st_o_r  <= acc_st_r;
    end
    case (cmd.step)
      STP_G0W: if (div_done) begin gx_r <= b2_x; gy_r <= div_r; end
      STP_GW:  if (div_done) begin gx_r <= gy_r; gy_r <= div_r; end
      STP_A2W: if (div_done) am2_r <= div_r[IW-1:0];
      STP_A1W: if (div_done) begin
        diff_r <= (am2_r >= am1) ? (am2_r - am1) : (am2_r + b2_r - am1);
      end
      STP_DGW: if (div_done) begin dg_r <= div_q; nosol_r <= (div_r != '0); end
      STP_M2W: if (div_done) m2_r <= div_q;
      STP_QW:  if (div_done) q_r <= div_q;
      STP_LW:  if (mul_done) begin lcm_r <= p_lo; lovf_r <= (p_hi != '0); end
      STP_QMW: if (div_done) begin
        r0_r <= m2_r;
        r1_r <= div_r;
        t0_r <= '0;
        t1_r <= 64'd1;
      end
      STP_IDW: if (div_done) begin qq_r <= div_q; tr_r <= div_r; end
      STP_IMW: if (mul_done) begin
        r0_r <= r1_r;
        r1_r <= tr_r;
        t0_r <= t1_r;
        t1_r <= tt;
      end
      STP_IFIN: inv_r <= t0_fix;
      STP_KMW: if (mul_done) kp_r <= p_lo;
      STP_KDW: if (div_done) k_r <= div_r;
      STP_BMW: if (mul_done) bk_r <= p_lo;
      STP_RDW: if (div_done) rr_r <= div_r;
      STP_XDW: if (div_done) mm_r <= div_r;
      STP_FIN1: begin
        rho_r <= (rho_s[DW] || (rho_s[DW-1:0] >= lcm_r)) ? (rho_s[DW-1:0] - lcm_r)
                                                         : rho_s[DW-1:0];
      end
      STP_FIN2: begin
        x1_r <= sum1[DW-1:0];
        c1_r <= sum1[DW];
        lt_r <= (rho_r < mm_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.div_done = div_done;
    stat.mul_done = mul_done;
    stat.gy_zero  = (gy_r == '0);
    stat.r1_zero  = (r1_r == '0);
    stat.nosol    = nosol_r;
    stat.lcm_ovf  = lovf_r;
    stat.acc_fail = (acc_st_r != ST_VALID);
  end

  assign out_merged_residue = res_o_r;
  assign out_merged_modulus = mod_o_r;
  assign out_status         = st_o_r;

endmodule

`default_nettype wire

@@ rtl/cma_ctrl.sv @@
// Sequencer for the merge: walks the gcd, inverse and final fix-up steps.
// Depends on cma_pkg; talks to cma_datapath through cma_cmd_t and cma_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module cma_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_start_req,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire cma_pkg::cma_stat_t stat,
  output cma_pkg::cma_cmd_t       cmd
);
  import cma_pkg::*;

  logic [5:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.step      = state_r;
    cmd.accept    = 1'b0;
    cmd.out_load  = 1'b0;
    out_valid_nxt = (out_valid_r && !out_stall) ? 1'b0 : out_valid_r;
    unique case (state_r)
      STP_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_start_req) begin
            state_nxt = STP_LOAD;
          end else if (stat.acc_fail) begin
            state_nxt = STP_OUT;
          end else begin
            state_nxt = STP_G0L;
          end
        end
      end
      STP_LOAD: state_nxt = STP_OUT;
      STP_G0L:  state_nxt = STP_G0W;
      STP_G0W:  if (stat.div_done) state_nxt = STP_GCHK;
      STP_GCHK: state_nxt = stat.gy_zero ? STP_A2L : STP_GL;
      STP_GL:   state_nxt = STP_GW;
      STP_GW:   if (stat.div_done) state_nxt = STP_GCHK;
      STP_A2L:  state_nxt = STP_A2W;
      STP_A2W:  if (stat.div_done) state_nxt = STP_A1L;
      STP_A1L:  state_nxt = STP_A1W;
      STP_A1W:  if (stat.div_done) state_nxt = STP_DGL;
      STP_DGL:  state_nxt = STP_DGW;
      STP_DGW:  if (stat.div_done) state_nxt = STP_DGC;
      STP_DGC:  state_nxt = stat.nosol ? STP_FNS : STP_M2L;
      STP_M2L:  state_nxt = STP_M2W;
      STP_M2W:  if (stat.div_done) state_nxt = STP_QL;
      STP_QL:   state_nxt = STP_QW;
      STP_QW:   if (stat.div_done) state_nxt = STP_LL;
      STP_LL:   state_nxt = STP_LW;
      STP_LW:   if (stat.mul_done) state_nxt = STP_LC;
      STP_LC:   state_nxt = stat.lcm_ovf ? STP_FOV : STP_QML;
      STP_QML:  state_nxt = STP_QMW;
      STP_QMW:  if (stat.div_done) state_nxt = STP_ICHK;
      STP_ICHK: state_nxt = stat.r1_zero ? STP_IFIN : STP_IDL;
      STP_IDL:  state_nxt = STP_IDW;
      STP_IDW:  if (stat.div_done) state_nxt = STP_IML;
      STP_IML:  state_nxt = STP_IMW;
      STP_IMW:  if (stat.mul_done) state_nxt = STP_ICHK;
      STP_IFIN: state_nxt = STP_KML;
      STP_KML:  state_nxt = STP_KMW;
      STP_KMW:  if (stat.mul_done) state_nxt = STP_KDL;
      STP_KDL:  state_nxt = STP_KDW;
      STP_KDW:  if (stat.div_done) state_nxt = STP_BML;
      STP_BML:  state_nxt = STP_BMW;
      STP_BMW:  if (stat.mul_done) state_nxt = STP_RDL;
      STP_RDL:  state_nxt = STP_RDW;
      STP_RDW:  if (stat.div_done) state_nxt = STP_XDL;
      STP_XDL:  state_nxt = STP_XDW;
      STP_XDW:  if (stat.div_done) state_nxt = STP_FIN1;
      STP_FIN1: state_nxt = STP_FIN2;
      STP_FIN2: state_nxt = STP_FIN3;
      STP_FIN3: state_nxt = STP_OUT;
      STP_FNS:  state_nxt = STP_OUT;
      STP_FOV:  state_nxt = STP_OUT;
      STP_OUT: begin
        // The result register is loaded only once the previous beat has left.
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = STP_IDLE;
        end
      end
      default: state_nxt = STP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != STP_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ rtl/congruence_merge_accumulator_core.sv @@
// Congruence merge accumulator: folds x = r (mod m) beats into one combined congruence.
// A start beat loads the accumulator directly, and a beat that arrives while the accumulator
// holds a failure passes the failure on; a merge runs the gcd, inverse and fix-up steps on the
// shared divide and multiply units. A stalled output holds off the next beat. One beat at a time.
// Synchronous active-low reset: residue 0, modulus 1, status valid.
`timescale 1ns / 1ps
`default_nettype none

module congruence_merge_accumulator_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [cma_pkg::IW-1:0] in_residue,
  input  wire logic [cma_pkg::IW-1:0] in_modulus,
  input  wire logic                   in_start_req,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [cma_pkg::DW-1:0]      out_merged_residue,
  output logic [cma_pkg::DW-1:0]      out_merged_modulus,
  output logic [1:0]                  out_status
);
  import cma_pkg::*;

  cma_cmd_t  cmd;
  cma_stat_t stat;

  cma_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_start_req (in_start_req),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  cma_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_residue         (in_residue),
    .in_modulus         (in_modulus),
    .stat               (stat),
    .out_merged_residue (out_merged_residue),
    .out_merged_modulus (out_merged_modulus),
    .out_status         (out_status)
  );

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_VALID || out_status == ST_NOSOL || out_status == ST_OVF))
    else $error("result status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_VALID) |->
      (out_merged_residue == '0 && out_merged_modulus == '0))
    else $error("failed result carries nonzero values");

  a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_VALID) |-> (out_merged_modulus != '0))
    else $error("valid result with zero modulus");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the beat was processed");

endmodule

`default_nettype wire
